// File: rtl/mhts_pkg.sv
// Shared constants for the min-heap timer scheduler.
`timescale 1ns / 1ps

package mhts_pkg;

    localparam int ID_W     = 6;
    localparam int ID_SPACE = 64;
    localparam int DELAY_W  = 32;
    localparam int INT_W    = 32;
    localparam int NOW_W    = 48;
    localparam int EL_W     = 48;
    localparam int ACT_W    = 2;
    localparam int STAT_W   = 2;
    localparam int IN_DATA_W  = 120;
    localparam int OUT_DATA_W = 56;

    localparam logic [ACT_W-1:0] ACT_SCHED  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_CANCEL = 2'd1;
    localparam logic [ACT_W-1:0] ACT_TICK   = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_ACTIVE   = 2'd1;
    localparam logic [STAT_W-1:0] ST_INACTIVE = 2'd2;

    localparam logic KIND_ACK  = 1'b0;
    localparam logic KIND_FIRE = 1'b1;

endpackage

// File: rtl/min_heap_timer_scheduler_top.sv
// Min-heap timer queue: schedule, cancel and tick over a heap memory.
`timescale 1ns / 1ps

// Timer queue held as a binary min-heap of expiry times in a single-port-read
// heap memory, with slot-to-position, interval and periodic memories beside it.
// One item is taken at a time; s_axis_tready is high only while the sequencer
// idles. Walking the heap up or down costs one registered memory read per entry
// visited, and a tick repeats a removal, plus a re-insert for a periodic timer,
// for each timer that fires. A tick emits fired results in expiry order, tlast on
// the final one; schedule and cancel each emit one acknowledgement.
module min_heap_timer_scheduler_top
    import mhts_pkg::*;
#(
    parameter int CAPACITY  = 64,
    parameter int TIME_BITS = 48
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // timer_id[5:0], delay[37:6], interval[69:38], periodic[70], now_ms[118:71]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // action[1:0]
    input  logic [ACT_W-1:0]      s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // fired_id[5:0], elapsed[53:6], status[55:54]
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // kind[0]
    output logic                  m_axis_tuser,
    output logic                  m_axis_tlast
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = IW + 1;
    localparam int TB = TIME_BITS;

    typedef enum logic [3:0] {
        S_IDLE, S_CRD, S_CPOS, S_RM, S_RML, S_UP, S_UPC, S_DN, S_DNL, S_DNR,
        S_TRD, S_TCK, S_TFI, S_TPER, S_FIN
    } t_state;

    function automatic logic [TB-1:0] sat_add(input logic [TB-1:0] a, input logic [TB-1:0] b);
        logic [TB:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TB] ? {TB{1'b1}} : s[TB-1:0];
    endfunction

    logic [ID_W-1:0]    w_id;
    logic [DELAY_W-1:0] w_delay;
    logic [INT_W-1:0]   w_interval;
    logic               w_periodic;
    logic [NOW_W-1:0]   w_now;

    assign w_id       = s_axis_tdata[5:0];
    assign w_delay    = s_axis_tdata[37:6];
    assign w_interval = s_axis_tdata[69:38];
    assign w_periodic = s_axis_tdata[70];
    assign w_now      = s_axis_tdata[118:71];

    // heap memory
    logic [TB-1:0]   mem_exp  [CAPACITY];
    logic [ID_W-1:0] mem_slot [CAPACITY];
    logic [TB-1:0]   r_hrd_e;
    logic [ID_W-1:0] r_hrd_s;
    logic            h_we;
    logic [IW-1:0]   h_wa, h_ra;
    logic [TB-1:0]   h_wexp;
    logic [ID_W-1:0] h_wslot;

    // slot memories
    logic [IW-1:0]    mem_pos [ID_SPACE];
    logic [INT_W-1:0] mem_int [ID_SPACE];
    logic             mem_per [ID_SPACE];
    logic [IW-1:0]    r_prd;
    logic [INT_W-1:0] r_int_rd;
    logic             r_per_rd;
    logic             p_we, s_we;
    logic [ID_W-1:0]  p_wa;
    logic [IW-1:0]    p_wd;

    t_state           r_state, n_state;
    logic [ID_W-1:0]  r_id, n_id;
    logic [TB-1:0]    r_now, n_now;
    logic [TB-1:0]    r_e_exp, n_e_exp;
    logic [ID_W-1:0]  r_e_slot, n_e_slot;
    logic [IW-1:0]    r_i, n_i;
    logic [CW-1:0]    r_count, n_count;
    logic             r_rm_first, n_rm_first;
    logic             r_tick, n_tick;
    logic             r_ins, n_ins;
    logic [TB-1:0]    r_l_exp, n_l_exp;
    logic [ID_W-1:0]  r_l_slot, n_l_slot;
    logic [ID_SPACE-1:0] r_fired, n_fired;
    logic [ID_SPACE-1:0] r_active, n_active;
    logic [ID_W-1:0]  r_s, n_s;
    logic [TB-1:0]    r_exp, n_exp;
    logic [INT_W-1:0] r_int, n_int;
    logic             r_per, n_per;
    logic             r_pv, n_pv;
    logic             r_pkind, n_pkind;
    logic [ID_W-1:0]  r_pid, n_pid;
    logic [EL_W-1:0]  r_pel, n_pel;
    logic [STAT_W-1:0] r_pst, n_pst;
    logic             r_ov, n_ov;
    logic             r_okind, n_okind;
    logic [ID_W-1:0]  r_oid, n_oid;
    logic [EL_W-1:0]  r_oel, n_oel;
    logic [STAT_W-1:0] r_ost, n_ost;
    logic             r_olast, n_olast;

    logic            w_acc, w_free, w_id_ok;
    logic [IW+1:0]   w_c, w_c1;
    logic [TB-1:0]   w_m_e;
    logic [ID_W-1:0] w_m_s;
    logic [IW-1:0]   w_m_i;
    logic            w_fire;
    logic [TB-1:0]   w_el;
    t_state          w_done;

    assign w_acc   = s_axis_tvalid && s_axis_tready;
    assign w_free  = !r_ov || m_axis_tready;
    assign w_id_ok = 32'(w_id) < 32'(CAPACITY);
    assign w_c     = {1'b0, r_i, 1'b1};
    assign w_c1    = w_c + (IW+2)'(1);
    assign w_fire  = (r_hrd_e <= r_now) && !r_fired[r_hrd_s];
    assign w_el    = sat_add(r_now - r_exp, TB'(r_int_rd));
    assign w_done  = r_tick ? (r_ins ? S_TRD : S_TPER) : S_FIN;

    always_comb begin
        if ((r_state == S_DNR) && (r_l_exp < r_hrd_e)) begin
            w_m_e = r_l_exp;
            w_m_s = r_l_slot;
            w_m_i = IW'(w_c);
        end else if (r_state == S_DNR) begin
            w_m_e = r_hrd_e;
            w_m_s = r_hrd_s;
            w_m_i = IW'(w_c1);
        end else begin
            w_m_e = r_hrd_e;
            w_m_s = r_hrd_s;
            w_m_i = IW'(w_c);
        end
    end

    always_comb begin
        unique case (r_state)
            S_RM:    h_ra = IW'(r_count - CW'(1));
            S_UP:    h_ra = IW'((r_i - IW'(1)) >> 1);
            S_DN:    h_ra = IW'(w_c);
            S_DNL:   h_ra = IW'(w_c1);
            default: h_ra = '0;
        endcase
    end

    always_comb begin
        n_state = r_state; n_id = r_id; n_now = r_now; n_e_exp = r_e_exp;
        n_e_slot = r_e_slot; n_i = r_i; n_count = r_count; n_rm_first = r_rm_first;
        n_tick = r_tick; n_ins = r_ins; n_l_exp = r_l_exp; n_l_slot = r_l_slot;
        n_fired = r_fired; n_active = r_active; n_s = r_s; n_exp = r_exp;
        n_int = r_int; n_per = r_per; n_pv = r_pv; n_pkind = r_pkind; n_pid = r_pid;
        n_pel = r_pel; n_pst = r_pst; n_ov = r_ov; n_okind = r_okind; n_oid = r_oid;
        n_oel = r_oel; n_ost = r_ost; n_olast = r_olast;
        h_we = 1'b0; h_wa = r_i; h_wexp = r_e_exp; h_wslot = r_e_slot;
        p_we = 1'b0; p_wa = r_e_slot; p_wd = r_i; s_we = 1'b0;

        if (r_ov && m_axis_tready) begin
            n_ov = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    n_id    = w_id;
                    n_now   = TB'(w_now);
                    n_tick  = 1'b0;
                    n_pkind = KIND_ACK;
                    n_pid   = w_id;
                    n_pel   = '0;
                    n_pst   = ST_OK;
                    priority if (s_axis_tuser == ACT_SCHED) begin
                        n_pv = 1'b1;
                        if (!w_id_ok) begin
                            n_pst   = ST_INACTIVE;
                            n_state = S_FIN;
                        end else if (r_active[w_id]) begin
                            n_pst   = ST_ACTIVE;
                            n_state = S_FIN;
                        end else begin
                            n_active[w_id] = 1'b1;
                            s_we     = 1'b1;
                            n_e_exp  = sat_add(TB'(w_now), TB'(w_delay));
                            n_e_slot = w_id;
                            if (r_count >= CW'(CAPACITY)) begin
                                n_state = S_FIN;
                            end else begin
                                n_i        = IW'(r_count);
                                n_count    = r_count + CW'(1);
                                n_rm_first = 1'b0;
                                n_state    = S_UP;
                            end
                        end
                    end else if (s_axis_tuser == ACT_CANCEL) begin
                        n_pv = 1'b1;
                        if (!w_id_ok || !r_active[w_id]) begin
                            n_pst   = ST_INACTIVE;
                            n_state = S_FIN;
                        end else begin
                            n_active[w_id] = 1'b0;
                            n_state = S_CRD;
                        end
                    end else if (s_axis_tuser == ACT_TICK) begin
                        n_pv    = 1'b0;
                        n_tick  = 1'b1;
                        n_fired = '0;
                        n_state = S_TRD;
                    end else begin
                        n_pv = 1'b0;
                    end
                end
            end
            S_CRD: n_state = S_CPOS;
            S_CPOS: begin
                n_i     = r_prd;
                n_state = S_RM;
            end
            S_RM: begin
                if ((r_count == '0) || (CW'(r_i) >= r_count)) begin
                    n_state = w_done;
                end else if (CW'(r_i) == r_count - CW'(1)) begin
                    n_count = r_count - CW'(1);
                    n_state = w_done;
                end else begin
                    n_count = r_count - CW'(1);
                    n_state = S_RML;
                end
            end
            S_RML: begin
                n_e_exp  = r_hrd_e;
                n_e_slot = r_hrd_s;
                if (r_i != '0) begin
                    n_rm_first = 1'b1;
                    n_state    = S_UP;
                end else begin
                    n_state = S_DN;
                end
            end
            S_UP: begin
                if (r_i == '0) begin
                    h_we = 1'b1; p_we = 1'b1;
                    n_state = w_done;
                end else begin
                    n_state = S_UPC;
                end
            end
            S_UPC: begin
                if (r_e_exp < r_hrd_e) begin
                    h_we = 1'b1; h_wexp = r_hrd_e; h_wslot = r_hrd_s;
                    p_we = 1'b1; p_wa = r_hrd_s;
                    n_i        = IW'((r_i - IW'(1)) >> 1);
                    n_rm_first = 1'b0;
                    n_state    = S_UP;
                end else if (r_rm_first) begin
                    n_rm_first = 1'b0;
                    n_state    = S_DN;
                end else begin
                    h_we = 1'b1; p_we = 1'b1;
                    n_state = w_done;
                end
            end
            S_DN: begin
                if ((IW+2)'(r_count) <= w_c) begin
                    h_we = 1'b1; p_we = 1'b1;
                    n_state = w_done;
                end else begin
                    n_state = S_DNL;
                end
            end
            S_DNL, S_DNR: begin
                if ((r_state == S_DNL) && (w_c1 < (IW+2)'(r_count))) begin
                    n_l_exp  = r_hrd_e;
                    n_l_slot = r_hrd_s;
                    n_state  = S_DNR;
                end else if (r_e_exp < w_m_e) begin
                    h_we = 1'b1; p_we = 1'b1;
                    n_state = w_done;
                end else begin
                    h_we = 1'b1; h_wexp = w_m_e; h_wslot = w_m_s;
                    p_we = 1'b1; p_wa = w_m_s;
                    n_i     = w_m_i;
                    n_state = S_DN;
                end
            end
            S_TRD: begin
                n_state = (r_count == '0) ? S_FIN : S_TCK;
            end
            S_TCK: begin
                if (!w_fire) begin
                    n_state = S_FIN;
                end else if (!r_pv || w_free) begin
                    if (r_pv) begin
                        n_ov = 1'b1; n_okind = r_pkind; n_oid = r_pid;
                        n_oel = r_pel; n_ost = r_pst; n_olast = 1'b0;
                    end
                    n_fired[r_hrd_s] = 1'b1;
                    n_s     = r_hrd_s;
                    n_exp   = r_hrd_e;
                    n_state = S_TFI;
                end
            end
            S_TFI: begin
                n_pv    = 1'b1;
                n_pkind = KIND_FIRE;
                n_pid   = r_s;
                n_pel   = EL_W'(w_el);
                n_pst   = ST_OK;
                n_int   = r_int_rd;
                n_per   = r_per_rd;
                n_ins   = 1'b0;
                n_i     = '0;
                n_state = S_RM;
            end
            S_TPER: begin
                if (!r_per) begin
                    n_active[r_s] = 1'b0;
                    n_state = S_TRD;
                end else if (r_count >= CW'(CAPACITY)) begin
                    n_state = S_TRD;
                end else begin
                    n_e_exp    = sat_add(r_now, TB'(r_int));
                    n_e_slot   = r_s;
                    n_i        = IW'(r_count);
                    n_count    = r_count + CW'(1);
                    n_ins      = 1'b1;
                    n_rm_first = 1'b0;
                    n_state    = S_UP;
                end
            end
            S_FIN: begin
                if (!r_pv) begin
                    n_state = S_IDLE;
                end else if (w_free) begin
                    n_ov = 1'b1; n_okind = r_pkind; n_oid = r_pid;
                    n_oel = r_pel; n_ost = r_pst; n_olast = 1'b1;
                    n_pv = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_active <= '0;
            r_pv     <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_active <= n_active;
            r_pv     <= n_pv;
            r_ov     <= n_ov;
        end
        r_id <= n_id; r_now <= n_now; r_e_exp <= n_e_exp; r_e_slot <= n_e_slot;
        r_i <= n_i; r_rm_first <= n_rm_first; r_tick <= n_tick; r_ins <= n_ins;
        r_l_exp <= n_l_exp; r_l_slot <= n_l_slot; r_fired <= n_fired; r_s <= n_s;
        r_exp <= n_exp; r_int <= n_int; r_per <= n_per; r_pkind <= n_pkind;
        r_pid <= n_pid; r_pel <= n_pel; r_pst <= n_pst; r_okind <= n_okind;
        r_oid <= n_oid; r_oel <= n_oel; r_ost <= n_ost; r_olast <= n_olast;
    end

    always_ff @(posedge i_clk) begin
        if (h_we) begin
            mem_exp[h_wa]  <= h_wexp;
            mem_slot[h_wa] <= h_wslot;
        end
        r_hrd_e <= mem_exp[h_ra];
        r_hrd_s <= mem_slot[h_ra];
    end

    always_ff @(posedge i_clk) begin
        if (p_we) begin
            mem_pos[p_wa] <= p_wd;
        end
        r_prd <= mem_pos[r_id];
    end

    always_ff @(posedge i_clk) begin
        if (s_we) begin
            mem_int[w_id] <= (w_interval == '0) ? INT_W'(1) : w_interval;
            mem_per[w_id] <= w_periodic;
        end
        r_int_rd <= mem_int[r_hrd_s];
        r_per_rd <= mem_per[r_hrd_s];
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {r_ost, r_oel, r_oid};
    assign m_axis_tuser  = r_okind;
    assign m_axis_tlast  = r_olast;

`ifndef SYNTH
    a_idle_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_pv)
        else $error("pending result left at idle");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("heap count beyond capacity");
    a_noop_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && (s_axis_tuser != ACT_SCHED) && (s_axis_tuser != ACT_CANCEL)
         && (s_axis_tuser != ACT_TICK)) |=> s_axis_tready)
        else $error("unused action not dropped");
    a_fire_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && (r_okind == KIND_FIRE)) |-> (r_ost == ST_OK))
        else $error("fired result with nonzero status");
`endif

endmodule

// File: verif/min_heap_timer_scheduler_top_tb.sv
// Testbench for the min-heap timer scheduler: random streams checked against a heap predictor.
`timescale 1ns / 1ps

module min_heap_timer_scheduler_top_tb;
    import mhts_pkg::*;

    localparam int NSLOT = 64;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic [NOW_W-1:0] TIME_MAX = '1;
    localparam logic [ACT_W-1:0] ACT_NOP = 2'd3;

    typedef struct {
        logic [ACT_W-1:0]   action;
        logic [ID_W-1:0]    timer_id;
        logic [DELAY_W-1:0] delay;
        logic [INT_W-1:0]   interval;
        logic               periodic;
        logic [NOW_W-1:0]   now_ms;
        bit                 wait_drain;
    } t_timer_cmd;

    typedef struct {
        logic               kind;
        logic [ID_W-1:0]    fired_id;
        logic [EL_W-1:0]    elapsed;
        logic [STAT_W-1:0]  status;
        logic               last;
    } t_timer_event;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [ACT_W-1:0]      s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  m_axis_tlast;

    min_heap_timer_scheduler_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    t_timer_cmd   pending_cmds[$];
    t_timer_event expected_events[$];
    t_timer_cmd   cur_cmd;
    bit           cmd_taken = 1'b0;
    int           send_gap = 0;
    int           recv_gap = 0;
    int           calm_left = 0;
    int           idle_cycles = 0;
    int           errors = 0;

    logic [NOW_W-1:0] model_expiry[NSLOT];
    logic [ID_W-1:0]  model_heap_id[NSLOT];
    int               model_pos[NSLOT];
    bit               model_active[NSLOT];
    logic [INT_W-1:0] model_interval[NSLOT];
    bit               model_periodic[NSLOT];
    int               model_count = 0;

    function automatic logic [NOW_W-1:0] time_sum(logic [NOW_W-1:0] a, logic [NOW_W-1:0] b);
        logic [NOW_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[NOW_W] ? TIME_MAX : s[NOW_W-1:0];
    endfunction

    function int pick_gap();
        int r;
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) calm_left = $urandom_range(20, 60);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task heap_swap(int i, int j);
        logic [NOW_W-1:0] e;
        logic [ID_W-1:0]  s;
        e = model_expiry[i];
        s = model_heap_id[i];
        model_expiry[i] = model_expiry[j];
        model_heap_id[i] = model_heap_id[j];
        model_expiry[j] = e;
        model_heap_id[j] = s;
        model_pos[model_heap_id[i]] = i;
        model_pos[model_heap_id[j]] = j;
    endtask

    task heap_up(int i);
        int p;
        while (i > 0) begin
            p = (i - 1) / 2;
            if (!(model_expiry[i] < model_expiry[p])) break;
            heap_swap(i, p);
            i = p;
        end
    endtask

    task heap_down(int i);
        int c;
        int m;
        forever begin
            c = 2 * i + 1;
            if (c >= model_count) break;
            m = c;
            if (c + 1 < model_count && !(model_expiry[c] < model_expiry[c + 1])) m = c + 1;
            if (model_expiry[i] < model_expiry[m]) break;
            heap_swap(i, m);
            i = m;
        end
    endtask

    task heap_push(logic [ID_W-1:0] slot, logic [NOW_W-1:0] expiry);
        if (model_count < NSLOT) begin
            model_expiry[model_count] = expiry;
            model_heap_id[model_count] = slot;
            model_pos[slot] = model_count;
            model_count++;
            heap_up(model_count - 1);
        end
    endtask

    task heap_pull(int p);
        int tail;
        if (model_count > 0 && p < model_count) begin
            tail = model_count - 1;
            model_count = tail;
            if (p != tail) begin
                model_expiry[p] = model_expiry[tail];
                model_heap_id[p] = model_heap_id[tail];
                model_pos[model_heap_id[p]] = p;
                if (p > 0 && model_expiry[p] < model_expiry[(p - 1) / 2]) heap_up(p);
                else heap_down(p);
            end
        end
    endtask

    task add_event(logic kind, logic [ID_W-1:0] id, logic [EL_W-1:0] el,
                   logic [STAT_W-1:0] st, logic last);
        t_timer_event ev;
        ev.kind = kind;
        ev.fired_id = id;
        ev.elapsed = el;
        ev.status = st;
        ev.last = last;
        expected_events.insert(expected_events.size(), ev);
    endtask

    task predict_timer_events(t_timer_cmd c);
        bit               fired[NSLOT];
        int               n;
        logic [ID_W-1:0]  s;
        logic [NOW_W-1:0] exp_t;
        logic [INT_W-1:0] ivl;
        n = 0;
        case (c.action)
            ACT_SCHED: begin
                if (model_active[c.timer_id]) begin
                    add_event(KIND_ACK, c.timer_id, '0, ST_ACTIVE, 1'b1);
                end else begin
                    ivl = (c.interval == '0) ? INT_W'(1) : c.interval;
                    model_active[c.timer_id] = 1'b1;
                    model_interval[c.timer_id] = ivl;
                    model_periodic[c.timer_id] = c.periodic;
                    heap_push(c.timer_id, time_sum(c.now_ms, NOW_W'(c.delay)));
                    add_event(KIND_ACK, c.timer_id, '0, ST_OK, 1'b1);
                end
            end
            ACT_CANCEL: begin
                if (!model_active[c.timer_id]) begin
                    add_event(KIND_ACK, c.timer_id, '0, ST_INACTIVE, 1'b1);
                end else begin
                    heap_pull(model_pos[c.timer_id]);
                    model_active[c.timer_id] = 1'b0;
                    add_event(KIND_ACK, c.timer_id, '0, ST_OK, 1'b1);
                end
            end
            ACT_TICK: begin
                foreach (fired[k]) fired[k] = 1'b0;
                while (model_count > 0 && model_expiry[0] <= c.now_ms && n < NSLOT) begin
                    s = model_heap_id[0];
                    exp_t = model_expiry[0];
                    if (fired[s]) break;
                    fired[s] = 1'b1;
                    heap_pull(0);
                    if (model_periodic[s])
                        heap_push(s, time_sum(c.now_ms, NOW_W'(model_interval[s])));
                    else
                        model_active[s] = 1'b0;
                    add_event(KIND_FIRE, s,
                              time_sum(c.now_ms - exp_t, NOW_W'(model_interval[s])),
                              ST_OK, 1'b0);
                    n++;
                end
                if (n > 0) expected_events[$].last = 1'b1;
            end
            default: ;
        endcase
    endtask

    task queue_cmd(logic [ACT_W-1:0] act, logic [ID_W-1:0] id, logic [DELAY_W-1:0] dly,
                   logic [INT_W-1:0] ivl, logic per, logic [NOW_W-1:0] now, bit drain);
        t_timer_cmd c;
        c.action = act;
        c.timer_id = id;
        c.delay = dly;
        c.interval = ivl;
        c.periodic = per;
        c.now_ms = now;
        c.wait_drain = drain;
        pending_cmds.insert(pending_cmds.size(), c);
    endtask

    function automatic logic [NOW_W-1:0] rand_time();
        return NOW_W'({$urandom(), $urandom()});
    endfunction

    // drive inputs
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            m_axis_tready <= 1'b0;
        end else begin
            if (s_axis_tvalid && !cmd_taken) begin
            end else if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                s_axis_tvalid <= 1'b0;
            end else if (pending_cmds.size() > 0 &&
                         !(pending_cmds[0].wait_drain && expected_events.size() > 0)) begin
                cur_cmd = pending_cmds.pop_front();
                s_axis_tdata <= {1'b0, cur_cmd.now_ms, cur_cmd.periodic, cur_cmd.interval,
                                 cur_cmd.delay, cur_cmd.timer_id};
                s_axis_tuser <= cur_cmd.action;
                s_axis_tvalid <= 1'b1;
                send_gap <= pick_gap();
            end else begin
                s_axis_tvalid <= 1'b0;
            end
            if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if ($urandom_range(0, 3) == 0) recv_gap <= pick_gap();
            end
        end
    end

    // sample outputs, check and predict
    always @(posedge i_clk) begin
        t_timer_event want;
        logic [ID_W-1:0]   got_id;
        logic [EL_W-1:0]   got_el;
        logic [STAT_W-1:0] got_st;
        cmd_taken <= i_rst_n && s_axis_tvalid && s_axis_tready;
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: watchdog expired, %0d results outstanding",
                         $realtime, expected_events.size());
                $display("tb: failure");
                $finish;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                {got_st, got_el, got_id} = m_axis_tdata;
                if (expected_events.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected transaction, expected none, actual id=%0d kind=%0b",
                             $realtime, got_id, m_axis_tuser);
                end else begin
                    want = expected_events.pop_front();
                    if (want.kind !== m_axis_tuser || want.fired_id !== got_id ||
                        want.elapsed !== got_el || want.status !== got_st ||
                        want.last !== m_axis_tlast) begin
                        errors++;
                        $display("%0t: mismatch, expected kind=%0b id=%0d el=%0h st=%0d last=%0b",
                                 $realtime, want.kind, want.fired_id, want.elapsed,
                                 want.status, want.last);
                        $display("%0t:           actual kind=%0b id=%0d el=%0h st=%0d last=%0b",
                                 $realtime, m_axis_tuser, got_id, got_el, got_st,
                                 m_axis_tlast);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) predict_timer_events(cur_cmd);
        end
    end

    initial begin
        logic [NOW_W-1:0] t;
        logic [NOW_W-1:0] now;
        logic [DELAY_W-1:0] dly;
        logic [INT_W-1:0] ivl;
        int r;
        int tail_wait;
        foreach (model_active[k]) model_active[k] = 1'b0;

        queue_cmd(ACT_SCHED, 0, 0, 0, 1, 0, 0);
        queue_cmd(ACT_SCHED, 0, 7, 7, 0, 0, 0);
        queue_cmd(ACT_CANCEL, 63, 0, 0, 0, 0, 0);
        queue_cmd(ACT_SCHED, 63, '1, '1, 0, 0, 0);
        queue_cmd(ACT_NOP, 12, '1, '1, 1, TIME_MAX, 0);
        queue_cmd(ACT_TICK, 0, 0, 0, 0, 0, 0);
        queue_cmd(ACT_TICK, 0, 0, 0, 0, 0, 0);
        queue_cmd(ACT_SCHED, 5, 10, 3, 0, 0, 0);
        queue_cmd(ACT_SCHED, 6, 10, 7, 1, 0, 0);
        queue_cmd(ACT_SCHED, 7, 10, 0, 0, 0, 0);
        queue_cmd(ACT_TICK, 0, 0, 0, 0, 20, 0);
        queue_cmd(ACT_CANCEL, 63, 0, 0, 0, 20, 0);
        queue_cmd(ACT_CANCEL, 0, 0, 0, 0, 20, 0);
        queue_cmd(ACT_CANCEL, 6, 0, 0, 0, 20, 0);
        queue_cmd(ACT_SCHED, 42, 5, '1, 1, TIME_MAX - 2, 0);
        queue_cmd(ACT_TICK, 0, 0, 0, 0, TIME_MAX, 0);
        queue_cmd(ACT_CANCEL, 42, 0, 0, 0, TIME_MAX, 0);
        queue_cmd(ACT_TICK, 0, 0, 0, 0, 5, 1);

        t = 100;
        for (int n = 0; n < 150; n++) begin
            r = $urandom_range(0, 99);
            now = ($urandom_range(0, 9) == 0) ? rand_time() : t;
            dly = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 300);
            ivl = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 200);
            if (r < 38) begin
                queue_cmd(ACT_SCHED, ID_W'($urandom_range(0, 63)), dly, ivl,
                          1'($urandom_range(0, 1)), now, n == 90);
            end else if (r < 52) begin
                queue_cmd(ACT_CANCEL, ID_W'($urandom_range(0, 63)), dly, ivl,
                          1'($urandom_range(0, 1)), now, n == 90);
            end else if (r < 92) begin
                t = t + NOW_W'($urandom_range(0, 150));
                queue_cmd(ACT_TICK, ID_W'($urandom()), dly, ivl, 1'($urandom_range(0, 1)),
                          (r < 89) ? t : rand_time(), n == 90);
            end else begin
                queue_cmd(ACT_NOP, ID_W'($urandom()), DELAY_W'($urandom()),
                          INT_W'($urandom()), 1'($urandom_range(0, 1)),
                          rand_time(), n == 90);
                n--;
            end
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (pending_cmds.size() > 0 || s_axis_tvalid) @(posedge i_clk);
        while (expected_events.size() > 0) @(posedge i_clk);
        tail_wait = 0;
        while (tail_wait < 300 && expected_events.size() == 0 && !m_axis_tvalid) begin
            @(posedge i_clk);
            tail_wait++;
        end
        repeat (2) @(posedge i_clk);
        if (errors == 0 && expected_events.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
